@@ rtl/eulr_pkg.sv @@
// Shared types, constants and CORDIC table for the Euler rotate/translate pipeline.
package eulr_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int DEG_FRAC        = 24;
    localparam int TRIG_ONE_SHIFT  = 30;
    localparam int MAX_STAGES      = 24;
    localparam int ANG_SHIFT       = DEG_FRAC - ANGLE_FRAC_BITS;

    // reduced angle in input units, wide enough for twice a full turn
    typedef logic signed [17:0] ang_t;
    localparam ang_t FULL_TURN = ang_t'(360 << ANGLE_FRAC_BITS);
    localparam ang_t HALF_TURN = ang_t'(180 << ANGLE_FRAC_BITS);
    localparam ang_t QUARTER   = ang_t'(90 << ANGLE_FRAC_BITS);

    // CORDIC x/y in Q2.30, z in degrees Q24
    typedef logic signed [32:0] cval_t;
    localparam cval_t CORDIC_GAIN = 33'sd652032874;
    localparam cval_t TRIG_ONE    = cval_t'(1) <<< TRIG_ONE_SHIFT;

    typedef logic signed [31:0] trig_t;
    typedef logic signed [32:0] coord_t;
    typedef logic signed [63:0] acc_t;

    localparam acc_t  ROUND_HALF = acc_t'(1) <<< (TRIG_ONE_SHIFT - 1);
    localparam coord_t COORD_LIM = 33'sh0_FFFF_FFFF;

    typedef struct packed {
        cval_t x;
        cval_t y;
        cval_t z;
        logic  neg;
    } cordic_t;

    typedef struct packed {
        trig_t s;
        trig_t c;
    } sc_t;

    function automatic cval_t atan_deg(input int i);
        cval_t r;
        case (i)
            0:  r = 33'sd754974720;
            1:  r = 33'sd445687602;
            2:  r = 33'sd235489089;
            3:  r = 33'sd119537938;
            4:  r = 33'sd60000934;
            5:  r = 33'sd30029717;
            6:  r = 33'sd15018523;
            7:  r = 33'sd7509720;
            8:  r = 33'sd3754917;
            9:  r = 33'sd1877466;
            10: r = 33'sd938734;
            11: r = 33'sd469367;
            12: r = 33'sd234684;
            13: r = 33'sd117342;
            14: r = 33'sd58671;
            15: r = 33'sd29335;
            16: r = 33'sd14668;
            17: r = 33'sd7334;
            18: r = 33'sd3667;
            19: r = 33'sd1833;
            20: r = 33'sd917;
            21: r = 33'sd458;
            22: r = 33'sd229;
            23: r = 33'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

    // clamp to [-1, 1] in Q2.30, then apply the quadrant sign
    function automatic trig_t trig_out(input cval_t v, input logic neg);
        cval_t t;
        t = (v > TRIG_ONE) ? TRIG_ONE : ((v < -TRIG_ONE) ? -TRIG_ONE : v);
        if (neg)
        begin
            t = -t;
        end
        return t[31:0];
    endfunction

endpackage

@@ rtl/eulr_angle_fold.sv @@
// Angle reduction to one turn and quadrant fold into the CORDIC range.
module eulr_angle_fold import eulr_pkg::*; (
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output cordic_t            lane
);
    cordic_t lane_reg, lane_next;
    ang_t    a, r;
    logic    neg;

    always_comb
    begin
        a   = ang_t'(angle);
        neg = 1'b0;
        if (a < 0)
        begin
            r = (a < -FULL_TURN) ? a + FULL_TURN + FULL_TURN : a + FULL_TURN;
        end
        else if (a >= FULL_TURN)
        begin
            r = a - FULL_TURN;
        end
        else
        begin
            r = a;
        end
        if (r >= HALF_TURN)
        begin
            r = r - FULL_TURN;
        end
        if (r > QUARTER)
        begin
            r   = r - HALF_TURN;
            neg = 1'b1;
        end
        else if (r < -QUARTER)
        begin
            r   = r + HALF_TURN;
            neg = 1'b1;
        end
        lane_next.x   = CORDIC_GAIN;
        lane_next.y   = '0;
        lane_next.z   = cval_t'(r) <<< ANG_SHIFT;
        lane_next.neg = neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;
endmodule

@@ rtl/eulr_cordic_stage.sv @@
// One registered micro-rotation of the rotation-mode CORDIC.
module eulr_cordic_stage import eulr_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic    clk,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);
    cordic_t dout_reg, dout_next;
    cval_t   dx, dy, at;

    always_comb
    begin
        dx        = din.y >>> STAGE;
        dy        = din.x >>> STAGE;
        at        = atan_deg(STAGE);
        dout_next = din;
        if (din.z >= 0)
        begin
            dout_next.x = din.x - dx;
            dout_next.y = din.y + dy;
            dout_next.z = din.z - at;
        end
        else
        begin
            dout_next.x = din.x + dx;
            dout_next.y = din.y - dy;
            dout_next.z = din.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;
endmodule

@@ rtl/eulr_rotate.sv @@
// Two-stage plane rotation: products, then sum, round and clamp.
module eulr_rotate import eulr_pkg::*; (
    input  logic   clk,
    input  logic   en,
    input  coord_t a,
    input  coord_t b,
    input  sc_t    sc,
    output coord_t p,
    output coord_t q
);
    logic signed [64:0] ac_full, bs_full, as_full, bc_full;
    acc_t   ac_reg, bs_reg, as_reg, bc_reg;
    acc_t   p_sum, q_sum;
    logic signed [33:0] p_sh, q_sh;
    coord_t p_reg, q_reg, p_next, q_next;

    assign ac_full = a * sc.c;
    assign bs_full = b * sc.s;
    assign as_full = a * sc.s;
    assign bc_full = b * sc.c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg <= ac_full[63:0];
            bs_reg <= bs_full[63:0];
            as_reg <= as_full[63:0];
            bc_reg <= bc_full[63:0];
        end
    end

    // round half up, then hold within the intermediate range
    always_comb
    begin
        p_sum = ac_reg - bs_reg + ROUND_HALF;
        q_sum = as_reg + bc_reg + ROUND_HALF;
        p_sh  = p_sum[63:30];
        q_sh  = q_sum[63:30];
        if (p_sh > 34'(COORD_LIM))
            p_next = COORD_LIM;
        else if (p_sh < -34'(COORD_LIM))
            p_next = -COORD_LIM;
        else
            p_next = p_sh[32:0];
        if (q_sh > 34'(COORD_LIM))
            q_next = COORD_LIM;
        else if (q_sh < -34'(COORD_LIM))
            q_next = -COORD_LIM;
        else
            q_next = q_sh[32:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
            q_reg <= q_next;
        end
    end

    assign p = p_reg;
    assign q = q_reg;
endmodule

@@ rtl/euler_xyz_rotate_translate.sv @@
// Top level: Euler x-y-z rotation of a Q16.16 point plus a common offset, fully pipelined.
// The stages are: fold, one CORDIC stage per iteration, trig clamp,
// two stages per plane rotation for three rotations, and the offset/saturate stage.
// Throughput is one point per cycle; a stalled output freezes the whole pipeline in place.
// Reset clears the valid bits only; data registers are not reset.
module euler_xyz_rotate_translate import eulr_pkg::*; #(
    parameter int TRIG_STAGES = 18
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic signed [15:0] angle_about_x,
    input  logic signed [15:0] angle_about_y,
    input  logic signed [15:0] angle_about_z,
    input  logic signed [31:0] offset,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] result_x,
    output logic signed [31:0] result_y,
    output logic signed [31:0] result_z
);
    localparam int LAT   = TRIG_STAGES + 9;
    localparam int NSIDE = TRIG_STAGES + 2;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] d;
    } side_t;

    logic               en;
    logic [LAT-1:0]     v_reg;
    side_t              side_reg [NSIDE];
    cordic_t            chain [3][TRIG_STAGES+1];
    sc_t                sc_a_reg, sc_b_reg, sc_c_reg;
    logic signed [15:0] ang [3];

    assign en           = !(v_reg[LAT-1] && result_stall);
    assign item_stall   = !en;
    assign result_valid = v_reg[LAT-1];

    assign ang[0] = angle_about_x;
    assign ang[1] = angle_about_y;
    assign ang[2] = angle_about_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], item_valid};
        end
    end

    // carry point and offset alongside the trig pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= '{x: point_x, y: point_y, z: point_z, d: offset};
            for (int k = 1; k < NSIDE; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        eulr_angle_fold u_fold (
            .clk  (clk),
            .en   (en),
            .angle(ang[l]),
            .lane (chain[l][0])
        );
        for (genvar i = 0; i < TRIG_STAGES; i++)
        begin : g_stage
            eulr_cordic_stage #(.STAGE(i)) u_stage (
                .clk (clk),
                .en  (en),
                .din (chain[l][i]),
                .dout(chain[l][i+1])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_a_reg.s <= trig_out(chain[0][TRIG_STAGES].y, chain[0][TRIG_STAGES].neg);
            sc_a_reg.c <= trig_out(chain[0][TRIG_STAGES].x, chain[0][TRIG_STAGES].neg);
            sc_b_reg.s <= trig_out(chain[1][TRIG_STAGES].y, chain[1][TRIG_STAGES].neg);
            sc_b_reg.c <= trig_out(chain[1][TRIG_STAGES].x, chain[1][TRIG_STAGES].neg);
            sc_c_reg.s <= trig_out(chain[2][TRIG_STAGES].y, chain[2][TRIG_STAGES].neg);
            sc_c_reg.c <= trig_out(chain[2][TRIG_STAGES].x, chain[2][TRIG_STAGES].neg);
        end
    end

    // rotation about x: (y, z)
    side_t  s0;
    coord_t y1, z1;
    assign s0 = side_reg[NSIDE-1];

    eulr_rotate u_rot_x (
        .clk(clk), .en(en),
        .a(coord_t'(s0.y)), .b(coord_t'(s0.z)), .sc(sc_a_reg),
        .p(y1), .q(z1)
    );

    coord_t x1_reg [2];
    logic signed [31:0] d1_reg [2];
    sc_t    scb1_reg [2], scc1_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg[0]   <= coord_t'(s0.x);
            d1_reg[0]   <= s0.d;
            scb1_reg[0] <= sc_b_reg;
            scc1_reg[0] <= sc_c_reg;
            x1_reg[1]   <= x1_reg[0];
            d1_reg[1]   <= d1_reg[0];
            scb1_reg[1] <= scb1_reg[0];
            scc1_reg[1] <= scc1_reg[0];
        end
    end

    // rotation about y: (z, x)
    coord_t z2, x2;

    eulr_rotate u_rot_y (
        .clk(clk), .en(en),
        .a(z1), .b(x1_reg[1]), .sc(scb1_reg[1]),
        .p(z2), .q(x2)
    );

    coord_t y2_reg [2];
    logic signed [31:0] d2_reg [2];
    sc_t    scc2_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y2_reg[0]   <= y1;
            d2_reg[0]   <= d1_reg[1];
            scc2_reg[0] <= scc1_reg[1];
            y2_reg[1]   <= y2_reg[0];
            d2_reg[1]   <= d2_reg[0];
            scc2_reg[1] <= scc2_reg[0];
        end
    end

    // rotation about z: (x, y)
    coord_t x3, y3;

    eulr_rotate u_rot_z (
        .clk(clk), .en(en),
        .a(x2), .b(y2_reg[1]), .sc(scc2_reg[1]),
        .p(x3), .q(y3)
    );

    coord_t z3_reg [2];
    logic signed [31:0] d3_reg [2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z3_reg[0] <= z2;
            d3_reg[0] <= d2_reg[1];
            z3_reg[1] <= z3_reg[0];
            d3_reg[1] <= d3_reg[0];
        end
    end

    // add offset and saturate to 32 bits
    function automatic logic signed [31:0] sat_add(input coord_t v, input logic signed [31:0] d);
        logic signed [33:0] s;
        s = 34'(v) + 34'(d);
        if (s > 34'sd2147483647)
            return 32'sh7FFF_FFFF;
        else if (s < -34'sd2147483648)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

    logic signed [31:0] res_x_reg, res_y_reg, res_z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_x_reg <= sat_add(x3, d3_reg[1]);
            res_y_reg <= sat_add(y3, d3_reg[1]);
            res_z_reg <= sat_add(z3_reg[1], d3_reg[1]);
        end
    end

    assign result_x = res_x_reg;
    assign result_y = res_y_reg;
    assign result_z = res_z_reg;

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> v_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(v_reg))
        else $error("pipeline advanced while output stalled");

    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_reg[LAT-2] |=> result_valid)
        else $error("item lost before output stage");
endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the Euler x-y-z rotate and translate pipeline.
`timescale 1ns / 100ps

module tb_top;
    import eulr_pkg::*;

    localparam int STAGES      = 18;
    localparam int PIPE_DEPTH  = STAGES + 9;
    localparam int TURN        = 360 * 64;
    localparam int RIGHT_ANGLE = 90 * 64;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] angle_about_x;
    logic signed [15:0] angle_about_y;
    logic signed [15:0] angle_about_z;
    logic signed [31:0] offset;
    logic               result_valid;
    logic               result_stall;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;

    point_t expected_points[$];
    int     mismatches;
    int     send_idle_pct;
    int     recv_idle_pct;
    logic   long_hold;
    event   hold_go;

    euler_xyz_rotate_translate #(.TRIG_STAGES(STAGES)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .angle_about_x (angle_about_x),
        .angle_about_y (angle_about_y),
        .angle_about_z (angle_about_z),
        .offset        (offset),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_x      (result_x),
        .result_y      (result_y),
        .result_z      (result_z)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // arctangent of 2^-i in degrees, 24 fraction bits
    function automatic longint atan_step(input int i);
        longint tab[24] = '{754974720, 445687602, 235489089, 119537938,
                            60000934, 30029717, 15018523, 7509720,
                            3754917, 1877466, 938734, 469367,
                            234684, 117342, 58671, 29335,
                            14668, 7334, 3667, 1833,
                            917, 458, 229, 115};
        return tab[i];
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic sin_cos(input logic signed [15:0] ang, output longint sn, output longint cs);
        longint a;
        longint z;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint one;
        logic   flip;
        one  = longint'(1) <<< 30;
        a    = longint'(ang) % TURN;
        cx   = 652032874;
        cy   = 0;
        flip = 1'b0;
        if (a < 0)
        begin
            a += TURN;
        end
        z = a <<< 18;
        if (z >= (longint'(180) <<< 24))
        begin
            z -= longint'(360) <<< 24;
        end
        // fold into the right half plane, negate the result afterwards
        if (z > (longint'(90) <<< 24))
        begin
            z -= longint'(180) <<< 24;
            flip = 1'b1;
        end
        else if (z < -(longint'(90) <<< 24))
        begin
            z += longint'(180) <<< 24;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx -= dx;
                cy += dy;
                z  -= atan_step(i);
            end
            else
            begin
                cx += dx;
                cy -= dy;
                z  += atan_step(i);
            end
        end
        cx = clip(cx, -one, one);
        cy = clip(cy, -one, one);
        cs = flip ? -cx : cx;
        sn = flip ? -cy : cy;
    endtask

    function automatic longint round_trig(input longint v);
        longint lim;
        lim = (longint'(1) <<< 32) - 1;
        return clip((v + (longint'(1) <<< 29)) >>> 30, -lim, lim);
    endfunction

    task automatic predict_point(input logic signed [31:0] px, input logic signed [31:0] py,
                                 input logic signed [31:0] pz, input logic signed [15:0] ax,
                                 input logic signed [15:0] ay, input logic signed [15:0] az,
                                 input logic signed [31:0] d, output point_t res);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint ny;
        longint nz;
        longint sn;
        longint cs;
        x = px;
        y = py;
        z = pz;
        // each plane rotation uses only the coordinates from before it
        sin_cos(ax, sn, cs);
        ny = round_trig(y * cs - z * sn);
        nz = round_trig(y * sn + z * cs);
        y  = ny;
        z  = nz;
        sin_cos(ay, sn, cs);
        nz = round_trig(z * cs - x * sn);
        nx = round_trig(z * sn + x * cs);
        z  = nz;
        x  = nx;
        sin_cos(az, sn, cs);
        nx = round_trig(x * cs - y * sn);
        ny = round_trig(x * sn + y * cs);
        res.x = 32'(clip(nx + longint'(d), -64'sd2147483648, 64'sd2147483647));
        res.y = 32'(clip(ny + longint'(d), -64'sd2147483648, 64'sd2147483647));
        res.z = 32'(clip(z + longint'(d), -64'sd2147483648, 64'sd2147483647));
    endtask

    // offer one point until the block takes it, with random gaps before it
    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                              input logic signed [31:0] pz, input logic signed [15:0] ax,
                              input logic signed [15:0] ay, input logic signed [15:0] az,
                              input logic signed [31:0] d);
        point_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        point_x       <= px;
        point_y       <= py;
        point_z       <= pz;
        angle_about_x <= ax;
        angle_about_y <= ay;
        angle_about_z <= az;
        offset        <= d;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        predict_point(px, py, pz, ax, ay, az, d, res);
        expected_points.push_back(res);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 0) ? 32'sh7FFF_FFFF - $urandom_range(255)
                                           : 32'sh8000_0000 + $urandom_range(255);
            2: return 32'($signed($urandom_range(65535 * 200)) - 65535 * 100);
            default: return $signed($urandom) >>> $urandom_range(31);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(3))
            0: return 16'($signed($urandom_range(10)) * RIGHT_ANGLE - 5 * RIGHT_ANGLE
                          + $signed($urandom_range(2)) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_point();
        send_point(rand_coord(), rand_coord(), rand_coord(),
                   rand_angle(), rand_angle(), rand_angle(), rand_coord());
    endtask

    task automatic test_extremes();
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 32'sh7FFF_FFFF);
        send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000);
        send_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                   16'sh7FFF, 16'sh8000, 16'sh7FFF, 0);
        send_point(0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000);
        send_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0, 32'sh0001_0000);
        send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                   16'(45 * 64), 16'(45 * 64), 0, 32'sh4000_0000);
        send_point(-1, -1, -1, -1, -1, -1, -1);
    endtask

    task automatic test_quadrants();
        logic signed [15:0] ang[12] = '{16'(90 * 64), -16'(90 * 64), 16'(90 * 64 + 1),
                                        -16'(90 * 64 + 1), 16'(180 * 64), -16'(180 * 64),
                                        16'(180 * 64 - 1), 16'(270 * 64), 16'(360 * 64),
                                        -16'(360 * 64), 16'(359 * 64 + 63), 16'(450 * 64)};
        foreach (ang[i])
        begin
            send_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                       ang[i], ang[(i + 5) % 12], ang[(i + 7) % 12], 0);
        end
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
        begin
            send_random_point();
        end
        send_idle_pct = 0;
    endtask

    // stall the output for a long stretch while points keep coming
    task automatic test_backpressure();
        recv_idle_pct = 0;
        send_idle_pct = 0;
        -> hold_go;
        repeat (100)
        begin
            send_random_point();
        end
    endtask

    always @(hold_go)
    begin
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        result_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        point_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %0d %0d %0d", result_x, result_y, result_z);
                end
            end
            else
            begin
                want = expected_points.pop_front();
                if (want.x !== result_x || want.y !== result_y || want.z !== result_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                 want.x, want.y, want.z, result_x, result_y, result_z);
                    end
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        mismatches    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold     = 1'b0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        result_stall  = 1'b0;
        point_x       = '0;
        point_y       = '0;
        point_z       = '0;
        angle_about_x = '0;
        angle_about_y = '0;
        angle_about_z = '0;
        offset        = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_quadrants();
        test_random(600, 16, 79);
        test_random(600, 79, 16);
        test_random(600, 0, 0);
        test_backpressure();
        item_valid <= 1'b0;
        recv_idle_pct = 0;

        while (expected_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ euler_xyz_rotate_translate.f @@
rtl/eulr_pkg.sv
rtl/eulr_angle_fold.sv
rtl/eulr_cordic_stage.sv
rtl/eulr_rotate.sv
rtl/euler_xyz_rotate_translate.sv
tb/tb_top.sv
